// ----- hw/rtl/mwm_pkg.sv -----
// Shared types, defaults and saturation helpers for the Mobius warp mesh.
package mwm_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_COEF_C,
        CFG_COEF_D,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_EDGE_MARGIN,
        CFG_QUALITY_MODE
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] coef_a;
        logic [63:0] coef_b;
        logic [63:0] coef_c;
        logic [63:0] coef_d;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [12:0] edge_margin;
        logic        quality_mode;
    } cfg_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] pixel_color;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic        [31:0] v0_color;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic        [31:0] v1_color;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic        [31:0] v2_color;
        logic               last_triangle;
    } triangle_t;

    // One mapped pixel, handed from the mapper to the mesh builder.
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] color;
        logic [31:0] px;
        logic [31:0] py;
        logic        outside;
    } mapped_t;

    function automatic logic signed [31:0] sat_sym(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sd2147483647;
        end
        else if (v < -64'sd2147483647) begin
            return -32'sd2147483647;
        end
        else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sd2147483647;
        end
        else if (v < -64'sd2147483648) begin
            return -32'sd2147483648;
        end
        else begin
            return v[31:0];
        end
    endfunction

endpackage

// ----- hw/rtl/mwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- hw/rtl/mwm_map.sv -----
// Front end: maps one pixel through the Mobius transform with a shared multiplier and divider.
module mwm_map #(
    parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mwm_pkg::cfg_t    cfg,
    input  logic             push,
    output logic             full,
    input  mwm_pkg::pixel_t  pixel,
    output logic             q_push,
    input  logic             q_full,
    output mwm_pkg::mapped_t q_word
);
    import mwm_pkg::*;

    localparam int DIV_STEPS = 63 + FRAC_BITS;
    localparam int CW        = $clog2(DIV_STEPS + 1);
    localparam logic [32:0] QUOT_CAP = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_SAT, S_PREP, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         step_reg;
    pixel_t             pix_reg;
    logic signed [13:0] rx_reg, ry_reg;
    logic signed [63:0] acc_reg [4];
    logic signed [31:0] sat_reg [4];
    logic signed [63:0] prod_reg;
    logic [CW-1:0]      cnt_reg;
    logic [62:0]        mag_reg [2];
    logic [63:0]        rem_reg [2];
    logic [32:0]        quo_reg [2];
    logic               ovf_reg [2];
    logic               neg_reg [2];
    logic signed [31:0] pt_reg  [2];
    logic               zero_reg;

    logic signed [31:0] mul_a, mul_b;
    logic [1:0]         acc_sel;
    logic               acc_sub;
    logic [63:0]        rem_shift [2];
    logic               rem_ge    [2];
    logic [32:0]        quo_fin   [2];
    logic signed [63:0] quo_sgn   [2];
    logic signed [63:0] centre    [2];
    logic signed [63:0] marg, wq, hq, px64, py64;
    logic               outside;

    // Operand selection for the fourteen products of one point.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        acc_sel = 2'd0;
        acc_sub = 1'b0;
        case (step_reg)
            4'd0:  begin mul_a = cfg.coef_a[63:32]; mul_b = 32'(rx_reg); acc_sel = 2'd0; end
            4'd1:  begin mul_a = cfg.coef_a[31:0];  mul_b = 32'(ry_reg); acc_sel = 2'd0;
                         acc_sub = 1'b1; end
            4'd2:  begin mul_a = cfg.coef_a[63:32]; mul_b = 32'(ry_reg); acc_sel = 2'd1; end
            4'd3:  begin mul_a = cfg.coef_a[31:0];  mul_b = 32'(rx_reg); acc_sel = 2'd1; end
            4'd4:  begin mul_a = cfg.coef_c[63:32]; mul_b = 32'(rx_reg); acc_sel = 2'd2; end
            4'd5:  begin mul_a = cfg.coef_c[31:0];  mul_b = 32'(ry_reg); acc_sel = 2'd2;
                         acc_sub = 1'b1; end
            4'd6:  begin mul_a = cfg.coef_c[63:32]; mul_b = 32'(ry_reg); acc_sel = 2'd3; end
            4'd7:  begin mul_a = cfg.coef_c[31:0];  mul_b = 32'(rx_reg); acc_sel = 2'd3; end
            4'd8:  begin mul_a = sat_reg[2]; mul_b = sat_reg[2]; acc_sel = 2'd0; end
            4'd9:  begin mul_a = sat_reg[3]; mul_b = sat_reg[3]; acc_sel = 2'd0; end
            4'd10: begin mul_a = sat_reg[0]; mul_b = sat_reg[2]; acc_sel = 2'd1; end
            4'd11: begin mul_a = sat_reg[1]; mul_b = sat_reg[3]; acc_sel = 2'd1; end
            4'd12: begin mul_a = sat_reg[1]; mul_b = sat_reg[2]; acc_sel = 2'd2; end
            4'd13: begin mul_a = sat_reg[0]; mul_b = sat_reg[3]; acc_sel = 2'd2;
                         acc_sub = 1'b1; end
            default: ;
        endcase
    end

    // Two restoring divider lanes share the denominator held in the first accumulator.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem_shift[i] = {rem_reg[i][62:0], mag_reg[i][62]};
            rem_ge[i]    = rem_shift[i] >= acc_reg[0];
            quo_fin[i]   = (ovf_reg[i] || quo_reg[i] > QUOT_CAP) ? QUOT_CAP : quo_reg[i];
            quo_sgn[i]   = neg_reg[i] ? -$signed(64'(quo_fin[i])) : $signed(64'(quo_fin[i]));
        end
        centre[0] = $signed(64'(cfg.image_width[12:1]) << FRAC_BITS);
        centre[1] = $signed(64'(cfg.image_height[12:1]) << FRAC_BITS);
    end

    assign marg = $signed(64'(cfg.edge_margin) << FRAC_BITS);
    assign wq   = $signed(64'(cfg.image_width) << FRAC_BITS);
    assign hq   = $signed(64'(cfg.image_height) << FRAC_BITS);
    assign px64 = 64'(pt_reg[0]);
    assign py64 = 64'(pt_reg[1]);
    assign outside = zero_reg || (px64 + marg < 0) || (px64 - marg > wq)
                     || (py64 + marg < 0) || (py64 - marg > hq);

    assign full   = (state_reg != S_IDLE);
    assign q_push = (state_reg == S_OUT) && !q_full;
    assign q_word = '{x: pix_reg.pixel_x, y: pix_reg.pixel_y, color: pix_reg.pixel_color,
                      px: pt_reg[0], py: pt_reg[1], outside: outside};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (push) state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:
            begin
                if (step_reg == 4'd7)
                begin
                    state_next = S_SAT;
                end
                else if (step_reg == 4'd13)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SAT:  state_next = S_MUL;
            S_PREP: state_next = (acc_reg[0] == 0) ? S_FIN : S_DIV;
            S_DIV:  if (cnt_reg == CW'(1)) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (!q_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    pix_reg    <= pixel;
                    rx_reg     <= $signed({2'b00, pixel.pixel_x})
                                  - $signed({2'b00, cfg.image_width[12:1]});
                    ry_reg     <= $signed({2'b00, pixel.pixel_y})
                                  - $signed({2'b00, cfg.image_height[12:1]});
                    acc_reg[0] <= 64'($signed(cfg.coef_b[63:32]));
                    acc_reg[1] <= 64'($signed(cfg.coef_b[31:0]));
                    acc_reg[2] <= 64'($signed(cfg.coef_d[63:32]));
                    acc_reg[3] <= 64'($signed(cfg.coef_d[31:0]));
                    step_reg   <= 4'd0;
                end
            end
            S_MUL: prod_reg <= mul_a * mul_b;
            S_ACC:
            begin
                acc_reg[acc_sel] <= acc_sub ? acc_reg[acc_sel] - prod_reg
                                            : acc_reg[acc_sel] + prod_reg;
                step_reg <= step_reg + 4'd1;
            end
            S_SAT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    sat_reg[i] <= sat_sym(acc_reg[i]);
                    acc_reg[i] <= '0;
                end
            end
            S_PREP:
            begin
                zero_reg <= (acc_reg[0] == 0);
                cnt_reg  <= CW'(DIV_STEPS);
                for (int i = 0; i < 2; i++)
                begin
                    neg_reg[i] <= acc_reg[i + 1][63];
                    mag_reg[i] <= acc_reg[i + 1][63] ? 63'(-acc_reg[i + 1])
                                                     : acc_reg[i + 1][62:0];
                    rem_reg[i] <= '0;
                    quo_reg[i] <= '0;
                    ovf_reg[i] <= 1'b0;
                end
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg - CW'(1);
                for (int i = 0; i < 2; i++)
                begin
                    rem_reg[i] <= rem_ge[i] ? rem_shift[i] - acc_reg[0] : rem_shift[i];
                    quo_reg[i] <= {quo_reg[i][31:0], rem_ge[i]};
                    ovf_reg[i] <= ovf_reg[i] | quo_reg[i][32];
                    mag_reg[i] <= {mag_reg[i][61:0], 1'b0};
                end
            end
            S_FIN:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    pt_reg[i] <= zero_reg ? 32'sd0 : sat32(centre[i] + quo_sgn[i]);
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/mwm_queue.sv -----
// Two-entry queue of mapped pixels between the mapper and the mesh builder.
module mwm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  mwm_pkg::mapped_t din,
    input  logic             pop,
    output logic             empty,
    output mwm_pkg::mapped_t dout
);
    import mwm_pkg::*;

    mapped_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hw/rtl/mwm_mesh.sv -----
// Back end: line stores, cell check and triangle emission.
module mwm_mesh #(
    parameter int MAX_WIDTH = mwm_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quality,
    input  logic               q_empty,
    output logic               q_pop,
    input  mwm_pkg::mapped_t   q_word,
    output logic               empty,
    input  logic               pop,
    output mwm_pkg::triangle_t triangle
);
    import mwm_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SH    = 26;
    localparam longint RECIP = ((64'd1 << SH) + MAX_WIDTH - 1) / MAX_WIDTH;
    localparam int LW    = 64 + 1 + 32;

    typedef enum logic [1:0] {B_IDLE, B_READ, B_EMIT} state_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] color;
    } vert_t;

    state_t      state_reg;
    mapped_t     cur_reg;
    logic [AW-1:0] addr_reg;
    logic [63:0] up_pt_reg, left_pt_reg, ul_pt_reg;
    logic        up_out_reg, left_out_reg, ul_out_reg;
    logic [31:0] up_col_reg, left_col_reg, ul_col_reg;
    logic [1:0]  tri_reg;
    logic        valid_reg;
    triangle_t   out_reg;

    logic [38:0] mod_prod;
    logic [12:0] mod_quo;
    logic [27:0] mod_rem;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] rd_data;
    logic [63:0] rd_pt;
    logic        rd_out;
    logic [31:0] rd_col;
    logic        cell_ok, out_load, last;
    vert_t       vp, va, vb, vc, w0, w1, w2;

    // Column modulo the line length, by a reciprocal that is exact for 12-bit columns.
    assign mod_prod = 39'(q_word.x) * 39'(RECIP);
    assign mod_quo  = 13'(mod_prod >> SH);
    assign mod_rem  = 28'(q_word.x) - 28'(mod_quo) * 28'(MAX_WIDTH);
    assign rd_addr  = AW'(mod_rem);

    mwm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    (state_reg == B_READ),
        .waddr (addr_reg),
        .wdata ({cur_reg.px, cur_reg.py, cur_reg.outside, cur_reg.color}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_pt  = rd_data[LW-1:33];
    assign rd_out = rd_data[32];
    assign rd_col = rd_data[31:0];

    assign cell_ok = (cur_reg.x != '0) && (cur_reg.y != '0) && !cur_reg.outside
                     && !left_out_reg && !rd_out && !ul_out_reg;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_load = !valid_reg || pop;
    assign last     = quality ? (tri_reg == 2'd3) : (tri_reg == 2'd2);
    assign empty    = !valid_reg;
    assign triangle = out_reg;

    assign vp = '{x: cur_reg.px, y: cur_reg.py, color: cur_reg.color};
    assign va = '{x: ul_pt_reg[63:32], y: ul_pt_reg[31:0], color: ul_col_reg};
    assign vb = '{x: up_pt_reg[63:32], y: up_pt_reg[31:0], color: up_col_reg};
    assign vc = '{x: left_pt_reg[63:32], y: left_pt_reg[31:0], color: left_col_reg};

    always_comb
    begin
        case (tri_reg)
            2'd0:    begin w0 = vb; w1 = vc; w2 = va; end
            2'd1:    begin w0 = va; w1 = vp; w2 = vb; end
            2'd2:    begin w0 = vb; w1 = vc; w2 = vp; end
            default: begin w0 = va; w1 = vp; w2 = vc; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            valid_reg    <= 1'b0;
            tri_reg      <= 2'd0;
            left_pt_reg  <= '0;
            left_out_reg <= 1'b1;
            left_col_reg <= '0;
            ul_pt_reg    <= '0;
            ul_out_reg   <= 1'b1;
            ul_col_reg   <= '0;
        end
        else
        begin
            // While emitting, a taken word is replaced by the next triangle below.
            if (pop && valid_reg && (state_reg != B_EMIT))
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg   <= q_word;
                        addr_reg  <= rd_addr;
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    up_pt_reg  <= rd_pt;
                    up_out_reg <= rd_out;
                    up_col_reg <= rd_col;
                    tri_reg    <= 2'd0;
                    if (cell_ok)
                    begin
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        ul_pt_reg    <= rd_pt;
                        ul_out_reg   <= rd_out;
                        ul_col_reg   <= rd_col;
                        left_pt_reg  <= {cur_reg.px, cur_reg.py};
                        left_out_reg <= cur_reg.outside;
                        left_col_reg <= cur_reg.color;
                        state_reg    <= B_IDLE;
                    end
                end
                B_EMIT:
                begin
                    if (out_load)
                    begin
                        valid_reg <= 1'b1;
                        out_reg   <= '{v0_x: w0.x, v0_y: w0.y, v0_color: w0.color,
                                       v1_x: w1.x, v1_y: w1.y, v1_color: w1.color,
                                       v2_x: w2.x, v2_y: w2.y, v2_color: w2.color,
                                       last_triangle: last};
                        if (last)
                        begin
                            ul_pt_reg    <= up_pt_reg;
                            ul_out_reg   <= up_out_reg;
                            ul_col_reg   <= up_col_reg;
                            left_pt_reg  <= {cur_reg.px, cur_reg.py};
                            left_out_reg <= cur_reg.outside;
                            left_col_reg <= cur_reg.color;
                            state_reg    <= B_IDLE;
                        end
                        else
                        begin
                            tri_reg <= quality ? tri_reg + 2'd1 : tri_reg + 2'd2;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/mobius_pixel_warp_mesh_top.sv -----
// Top level of the Mobius pixel warp mesh: configuration registers, mapper, queue and mesh builder.
//
//   Channel     Handshake           Word
//   pixel in    push / full         pixel (column, row, colour)
//   triangles   pop / empty         triangle (three vertices, last flag)
//   config      cfg_we              cfg_index, cfg_data
//
// The mapper (Q16.16 at the default FRAC_BITS) takes one pixel at a time: fourteen products
// through one shared multiplier, then one quotient bit per cycle in two divider lanes.
// The mesh builder reads the line store, then emits the triangles in turn, so the mapper sets the rate.
// Reset clears all control state and the left neighbours; the line stores are not cleared.
// A full result register stalls the builder, a full queue stalls the mapper, which raises full.
module mobius_pixel_warp_mesh_top #(
    parameter int MAX_WIDTH = mwm_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mwm_pkg::pixel_t    pixel,
    output logic               empty,
    input  logic               pop,
    output mwm_pkg::triangle_t triangle,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import mwm_pkg::*;

    localparam logic [63:0] COEF_ONE = 64'd1 << (32 + FRAC_BITS);

    cfg_t    cfg_reg;
    logic    q_push, q_full, q_pop, q_empty;
    mapped_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_a       <= COEF_ONE;
            cfg_reg.coef_b       <= '0;
            cfg_reg.coef_c       <= '0;
            cfg_reg.coef_d       <= COEF_ONE;
            cfg_reg.image_width  <= 13'd1024;
            cfg_reg.image_height <= 13'd768;
            cfg_reg.edge_margin  <= '0;
            cfg_reg.quality_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COEF_A:       cfg_reg.coef_a       <= cfg_data;
                CFG_COEF_B:       cfg_reg.coef_b       <= cfg_data;
                CFG_COEF_C:       cfg_reg.coef_c       <= cfg_data;
                CFG_COEF_D:       cfg_reg.coef_d       <= cfg_data;
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[12:0];
                CFG_EDGE_MARGIN:  cfg_reg.edge_margin  <= cfg_data[12:0];
                CFG_QUALITY_MODE: cfg_reg.quality_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mwm_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .q_push (q_push),
        .q_full (q_full),
        .q_word (q_in)
    );

    mwm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .din   (q_in),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_out)
    );

    mwm_mesh #(.MAX_WIDTH(MAX_WIDTH)) u_mesh (
        .clk      (clk),
        .rst_n    (rst_n),
        .quality  (cfg_reg.quality_mode),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_word   (q_out),
        .empty    (empty),
        .pop      (pop),
        .triangle (triangle)
    );

    // The mapper raises full once it has taken a pixel and keeps it up while it works on it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full ##1 full)
        else $error("mapper accepted a second pixel too early");

    // Reset leaves no result waiting and the input open.
    a_reset_clean: assert property (@(posedge clk)
        !rst_n |=> empty && !full)
        else $error("reset left a result or a busy mapper");

    // Configuration is not changed by anything but a write.
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

endmodule

// ----- tb/mobius_pixel_warp_mesh_check.sv -----
// Checker for the Mobius warp mesh: predicts the triangles of each pixel and compares them.
`timescale 1ns / 1ps
module mobius_pixel_warp_mesh_check
    import mwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  pixel_t    pixel,
    input  logic      empty,
    input  logic      pop,
    input  triangle_t triangle,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    output int        mismatches,
    output int        waiting,
    output int        triangles_checked
);

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int VP = 0;
    localparam int VA = 1;
    localparam int VB = 2;
    localparam int VC = 3;

    cfg_t cfg;
    logic [63:0] row_pt [MAX_WIDTH_DEF];
    logic        row_out [MAX_WIDTH_DEF];
    logic [31:0] row_col [MAX_WIDTH_DEF];
    logic [63:0] left_pt, ul_pt;
    logic        left_out, ul_out;
    logic [31:0] left_col, ul_col;
    triangle_t   triangles_due [$];

    function automatic longint clamp_sym(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483647)
        begin
            return -64'sd2147483647;
        end
        return v;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Scaled quotient, truncated toward zero with its magnitude capped at 2^32.
    function automatic longint scaled_quotient(input longint num, input logic [63:0] den);
        logic [63:0] mag;
        logic [79:0] quo;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        quo = {mag, 16'h0} / {16'h0, den};
        if (quo > 80'h1_0000_0000)
        begin
            quo = 80'h1_0000_0000;
        end
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic logic warp_point(input logic [11:0] x, input logic [11:0] y,
                                        output logic [31:0] px, output logic [31:0] py);
        longint cx, cy, rx, ry, ar, ai, br, bi, cr, ci, dr, di;
        longint nr, ni, mr, mi, marg, wq, hq, sx, sy;
        logic [63:0] den;
        cx = longint'(cfg.image_width >> 1);
        cy = longint'(cfg.image_height >> 1);
        rx = longint'(x) - cx;
        ry = longint'(y) - cy;
        ar = longint'($signed(cfg.coef_a[63:32]));
        ai = longint'($signed(cfg.coef_a[31:0]));
        br = longint'($signed(cfg.coef_b[63:32]));
        bi = longint'($signed(cfg.coef_b[31:0]));
        cr = longint'($signed(cfg.coef_c[63:32]));
        ci = longint'($signed(cfg.coef_c[31:0]));
        dr = longint'($signed(cfg.coef_d[63:32]));
        di = longint'($signed(cfg.coef_d[31:0]));
        nr = clamp_sym(ar * rx - ai * ry + br);
        ni = clamp_sym(ar * ry + ai * rx + bi);
        mr = clamp_sym(cr * rx - ci * ry + dr);
        mi = clamp_sym(cr * ry + ci * rx + di);
        den = 64'(mr * mr) + 64'(mi * mi);
        marg = longint'(cfg.edge_margin) <<< FRAC;
        wq = longint'(cfg.image_width) <<< FRAC;
        hq = longint'(cfg.image_height) <<< FRAC;
        if (den == 0)
        begin
            px = '0;
            py = '0;
            return 1'b1;
        end
        sx = clamp_s32((cx <<< FRAC) + scaled_quotient(nr * mr + ni * mi, den));
        sy = clamp_s32((cy <<< FRAC) + scaled_quotient(ni * mr - nr * mi, den));
        px = sx[31:0];
        py = sy[31:0];
        return (sx + marg < 0) || (sx - marg > wq) || (sy + marg < 0) || (sy - marg > hq);
    endfunction

    task automatic mesh_pixel(input pixel_t p);
        logic [31:0] px, py;
        logic        outp, up_out;
        logic [63:0] pt, up_pt;
        logic [31:0] up_col;
        logic [63:0] vpt [4];
        logic [31:0] vcol [4];
        int          order [4][3];
        triangle_t   tri_list [4];
        int          n;
        int          v;
        outp = warp_point(p.pixel_x, p.pixel_y, px, py);
        pt = {px, py};
        up_pt = row_pt[p.pixel_x];
        up_out = row_out[p.pixel_x];
        up_col = row_col[p.pixel_x];
        order = '{'{VB, VC, VA}, '{VA, VP, VB}, '{VB, VC, VP}, '{VA, VP, VC}};
        n = 0;
        if (p.pixel_x != 0 && p.pixel_y != 0 && !outp && !left_out && !up_out && !ul_out)
        begin
            vpt[VP] = pt;     vcol[VP] = p.pixel_color;
            vpt[VA] = ul_pt;  vcol[VA] = ul_col;
            vpt[VB] = up_pt;  vcol[VB] = up_col;
            vpt[VC] = left_pt; vcol[VC] = left_col;
            for (int t = 0; t < 4; t++)
            begin
                if (t % 2 == 1 && !cfg.quality_mode)
                begin
                    continue;
                end
                v = order[t][0];
                tri_list[n].v0_x = vpt[v][63:32];
                tri_list[n].v0_y = vpt[v][31:0];
                tri_list[n].v0_color = vcol[v];
                v = order[t][1];
                tri_list[n].v1_x = vpt[v][63:32];
                tri_list[n].v1_y = vpt[v][31:0];
                tri_list[n].v1_color = vcol[v];
                v = order[t][2];
                tri_list[n].v2_x = vpt[v][63:32];
                tri_list[n].v2_y = vpt[v][31:0];
                tri_list[n].v2_color = vcol[v];
                tri_list[n].last_triangle = 1'b0;
                n++;
            end
            tri_list[n - 1].last_triangle = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                triangles_due = {triangles_due, tri_list[k]};
            end
        end
        ul_pt = up_pt;
        ul_out = up_out;
        ul_col = up_col;
        left_pt = pt;
        left_out = outp;
        left_col = p.pixel_color;
        row_pt[p.pixel_x] = pt;
        row_out[p.pixel_x] = outp;
        row_col[p.pixel_x] = p.pixel_color;
    endtask

    task automatic check_triangle(input triangle_t got);
        triangle_t want;
        if (triangles_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Unexpected triangle %h", got);
            end
            return;
        end
        want = triangles_due.pop_front();
        triangles_checked++;
        if (got.v0_x !== want.v0_x || got.v0_y !== want.v0_y
            || got.v0_color !== want.v0_color || got.v1_x !== want.v1_x
            || got.v1_y !== want.v1_y || got.v1_color !== want.v1_color
            || got.v2_x !== want.v2_x || got.v2_y !== want.v2_y
            || got.v2_color !== want.v2_color
            || got.last_triangle !== want.last_triangle)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Triangle mismatch: expected %h", want);
                $display("                   actual   %h", got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.coef_a = 64'h0001_0000_0000_0000;
            cfg.coef_b = '0;
            cfg.coef_c = '0;
            cfg.coef_d = 64'h0001_0000_0000_0000;
            cfg.image_width = 13'd1024;
            cfg.image_height = 13'd768;
            cfg.edge_margin = '0;
            cfg.quality_mode = 1'b0;
            left_pt = '0;
            left_out = 1'b1;
            left_col = '0;
            ul_pt = '0;
            ul_out = 1'b1;
            ul_col = '0;
            triangles_due.delete();
            mismatches = 0;
            triangles_checked = 0;
            waiting = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COEF_A:       cfg.coef_a = cfg_data;
                    CFG_COEF_B:       cfg.coef_b = cfg_data;
                    CFG_COEF_C:       cfg.coef_c = cfg_data;
                    CFG_COEF_D:       cfg.coef_d = cfg_data;
                    CFG_IMAGE_WIDTH:  cfg.image_width = cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: cfg.image_height = cfg_data[12:0];
                    CFG_EDGE_MARGIN:  cfg.edge_margin = cfg_data[12:0];
                    CFG_QUALITY_MODE: cfg.quality_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                check_triangle(triangle);
            end
            if (push && !full)
            begin
                mesh_pixel(pixel);
            end
            waiting = triangles_due.size();
        end
    end

endmodule

// ----- tb/mobius_pixel_warp_mesh_top_test.sv -----
// Testbench top for the Mobius warp mesh: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module mobius_pixel_warp_mesh_top_test;
    import mwm_pkg::*;

    localparam int SETTLE_CYCLES = 2000;
    localparam int HOLD_CYCLES = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    pixel_t      pixel = '0;
    logic        empty;
    logic        pop = 1'b0;
    triangle_t   triangle;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          mismatches, waiting, triangles_checked;

    logic        written [MAX_WIDTH_DEF];
    logic        ul_known = 1'b0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int          pixels_sent = 0;
    int          settings_run = 1;

    always #5 clk = ~clk;

    mobius_pixel_warp_mesh_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .pixel(pixel),
        .empty(empty), .pop(pop), .triangle(triangle),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mobius_pixel_warp_mesh_check checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .pixel(pixel),
        .empty(empty), .pop(pop), .triangle(triangle),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .waiting(waiting), .triangles_checked(triangles_checked)
    );

    // Result side: random pauses, and one long hold-off on request.
    initial
    begin
        int hold_left;
        int pause_left;
        hold_left = 0;
        pause_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else if (pause_left > 0)
            begin
                pause_left--;
                pop = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                pause_left = $urandom_range(0, 9);
                pop = 1'b0;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    // A cell may only be meshed once its upper corners come from written columns.
    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                              input logic [31:0] color);
        int gap;
        if (x != 0 && y != 0 && !(written[x] && ul_known))
        begin
            y = '0;
        end
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            repeat (gap)
            begin
                @(negedge clk);
                push = 1'b0;
            end
        end
        @(negedge clk);
        push = 1'b1;
        pixel.pixel_x = x;
        pixel.pixel_y = y;
        pixel.pixel_color = color;
        do
        begin
            @(posedge clk);
        end
        while (full);
        ul_known = written[x];
        written[x] = 1'b1;
        pixels_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        push = 1'b0;
        while (waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_all(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
                           input logic [63:0] d, input int w, input int h, input int m,
                           input bit q);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_COEF_C, c);
        write_reg(CFG_COEF_D, d);
        write_reg(CFG_IMAGE_WIDTH, 64'(w));
        write_reg(CFG_IMAGE_HEIGHT, 64'(h));
        write_reg(CFG_EDGE_MARGIN, 64'(m));
        write_reg(CFG_QUALITY_MODE, 64'(q));
        settings_run++;
    endtask

    task automatic raster_frame(input int w, input int h);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                send_pixel(12'(x), 12'(y), $urandom());
            end
        end
    endtask

    // Small signed Q16.16 offset around a base value.
    function automatic logic [31:0] near(input int base, input int spread);
        return 32'(base + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    initial
    begin
        for (int i = 0; i < MAX_WIDTH_DEF; i++)
        begin
            written[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: colour extremes, a small mesh and the far columns and rows.
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'd1, 12'd0, 32'hFFFF_FFFF);
        send_pixel(12'd2, 12'd0, 32'hA5A5_5A5A);
        send_pixel(12'd3, 12'd0, 32'h0123_4567);
        send_pixel(12'd0, 12'd1, 32'h89AB_CDEF);
        send_pixel(12'd1, 12'd1, 32'hFFFF_0000);
        send_pixel(12'd2, 12'd1, 32'h0000_FFFF);
        send_pixel(12'd3, 12'd1, 32'h5555_AAAA);
        send_pixel(12'd4094, 12'd0, $urandom());
        send_pixel(12'd4095, 12'd0, $urandom());
        send_pixel(12'd4094, 12'd4095, $urandom());
        send_pixel(12'd4095, 12'd4095, $urandom());
        send_pixel(12'd0, 12'd4095, $urandom());
        send_pixel(12'd2048, 12'd2048, $urandom());
        drain();

        // Identity on a small image in quality mode; the result side holds off meanwhile.
        set_all(64'h0001_0000_0000_0000, 64'h0, 64'h0, 64'h0001_0000_0000_0000,
                8, 6, 0, 1'b1);
        hold_req = 1'b1;
        raster_frame(8, 4);
        drain();

        // Perturbed transforms with random sizes, margins and modes.
        for (int ph = 0; ph < 5; ph++)
        begin
            int w;
            int h;
            w = $urandom_range(3, 6);
            h = $urandom_range(2, 4);
            if (ph == 4)
            begin
                idle_on = 1'b0;
            end
            set_all({near(32'h1_0000, 16'h1800), near(0, 12'h800)},
                    {near(0, 32'h2_0000), near(0, 32'h2_0000)},
                    {near(0, 40), near(0, 40)},
                    {near(32'h1_0000, 12'h800), near(0, 12'h400)},
                    w, h, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            raster_frame(w, h);
            repeat (4) send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                  $urandom());
            drain();
            if (ph == 1)
            begin
                // Extreme coefficients, size and margin drive the mapper into saturation.
                set_all(64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, 64'h0,
                        64'h0000_0001_FFFF_FFFF, 4096, 4096, 4096, 1'b1);
                raster_frame(3, 2);
                drain();
                set_all(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_0000_0000,
                        64'h8000_0000_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2, 2, 0, 1'b0);
                raster_frame(3, 3);
                drain();
                // w = z / z: the centre pixel has a zero denominator and counts as outside.
                set_all(64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                        8, 8, 4096, 1'b1);
                raster_frame(6, 5);
                drain();
            end
        end

        if (mismatches == 0 && waiting == 0)
        begin
            $display("Run covered %0d pixels under %0d register settings, %0d triangles checked.",
                     pixels_sent, settings_run, triangles_checked);
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d triangles never arrived.", mismatches, waiting);
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timed out with %0d triangles outstanding.", waiting);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
